FILE: src/caf_pkg.sv
package caf_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int TABLE_LEN        = 24;
  localparam int ANG_LIMIT        = 23040;
  localparam int CFG_IDX_W        = 4;

  localparam logic [15:0] ALPHA_RST = 16'd59111;
  localparam logic [15:0] TS_RST    = 16'd6554;

  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TS    = 4'd1;

  // atan(2^-i) in 1/65536 degree
  function automatic logic [21:0] atan_val(input logic [4:0] idx);
    logic [21:0] v;
    case (idx)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: src/caf_sqrt.sv
module caf_sqrt (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [15:0] p,
  input  logic signed [15:0] q,
  output logic               done,
  output logic [15:0]        root
);
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_SQ   = 2'd1;
  localparam logic [1:0] PH_DIG  = 2'd2;

  logic [1:0]         phase_r;
  logic [3:0]         cnt_r;
  logic [31:0]        n_r;
  logic [19:0]        rem_r;
  logic [15:0]        root_r;
  logic               done_r;
  logic signed [15:0] q_r;
  logic signed [31:0] pp, qq;
  logic [19:0]        rem_sh, trial;
  logic               take;

  assign pp = p * p;
  assign qq = q_r * q_r;

  // one result bit per cycle
  assign rem_sh = {rem_r[17:0], n_r[31:30]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign take   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (phase_r)
        PH_IDLE: begin
          if (start) begin
            n_r     <= pp;
            q_r     <= q;
            phase_r <= PH_SQ;
          end
        end
        PH_SQ: begin
          n_r     <= n_r + qq;
          rem_r   <= '0;
          root_r  <= '0;
          cnt_r   <= 4'd15;
          phase_r <= PH_DIG;
        end
        PH_DIG: begin
          n_r    <= {n_r[29:0], 2'b00};
          rem_r  <= take ? rem_sh - trial : rem_sh;
          root_r <= {root_r[14:0], take};
          cnt_r  <= cnt_r - 4'd1;
          if (cnt_r == 4'd0) begin
            done_r  <= 1'b1;
            phase_r <= PH_IDLE;
          end
        end
        default: phase_r <= PH_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign root = root_r;
endmodule

FILE: src/caf_cordic.sv
module caf_cordic #(
  parameter int CORDIC_STEPS = caf_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [16:0] y_in,
  input  logic signed [16:0] x_in,
  output logic               done,
  output logic signed [16:0] res
);
  import caf_pkg::*;

  localparam int NSTEP = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam logic [4:0] LAST = 5'(NSTEP - 1);
  localparam logic signed [25:0] Z_HALF = 26'sd11796480;

  logic               busy_r, done_r;
  logic [4:0]         i_r;
  logic signed [33:0] x_r, y_r, xs, ys, x_nxt, y_nxt;
  logic signed [25:0] z_r, z_nxt, z_rnd, z_init;
  logic signed [25:0] step_ang;
  logic signed [16:0] res_r;
  logic signed [17:0] xa, ya;
  logic               xneg;

  assign xneg   = x_in[16];
  assign xa     = xneg ? -{x_in[16], x_in} : {x_in[16], x_in};
  assign ya     = xneg ? -{y_in[16], y_in} : {y_in[16], y_in};
  assign z_init = !xneg ? 26'sd0 : (y_in[16] ? -Z_HALF : Z_HALF);

  assign xs       = x_r >>> i_r;
  assign ys       = y_r >>> i_r;
  assign step_ang = $signed({4'b0000, atan_val(i_r)});

  always_comb begin
    if (!y_r[33]) begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + step_ang;
    end else begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - step_ang;
    end
  end

  assign z_rnd = (z_nxt + 26'sd256) >>> 9;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (x_in == '0 && y_in == '0) begin
          res_r  <= '0;
          done_r <= 1'b1;
        end else begin
          x_r    <= {{2{xa[17]}}, xa, 14'b0};
          y_r    <= {{2{ya[17]}}, ya, 14'b0};
          z_r    <= z_init;
          i_r    <= '0;
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        x_r <= x_nxt;
        y_r <= y_nxt;
        z_r <= z_nxt;
        i_r <= i_r + 5'd1;
        if (i_r == LAST) begin
          res_r  <= z_rnd[16:0];
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;
endmodule

FILE: src/caf_blend.sv
module caf_blend (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [23:0] prev,
  input  logic signed [15:0] rate,
  input  logic signed [17:0] meas,
  input  logic [15:0]        alpha,
  input  logic [15:0]        tstep,
  output logic               done,
  output logic signed [23:0] res
);
  import caf_pkg::*;

  localparam logic signed [26:0] LIM_P = 27'(ANG_LIMIT);
  localparam logic signed [26:0] LIM_N = -27'(ANG_LIMIT);

  logic               busy_r, done_r;
  logic [4:0]         cnt_r;
  logic signed [37:0] pred_r;
  logic signed [30:0] m13_r;
  logic [16:0]        a_sr_r, w_sr_r;
  logic signed [55:0] acc_r, acc_nxt, acc_rnd;
  logic signed [32:0] prod;
  logic signed [26:0] q;
  logic signed [23:0] sat, res_r;

  assign prod = rate * $signed({1'b0, tstep});

  // msb first shift-and-add of both weights
  assign acc_nxt = (acc_r <<< 1)
                 + (a_sr_r[16] ? 56'(pred_r) : 56'sd0)
                 + (w_sr_r[16] ? 56'(m13_r) : 56'sd0);
  assign acc_rnd = acc_nxt + (56'sd1 <<< 28);
  assign q       = acc_rnd[55:29];

  always_comb begin
    if (q > LIM_P)      sat = 24'(LIM_P);
    else if (q < LIM_N) sat = 24'(LIM_N);
    else                sat = q[23:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        pred_r <= {prev[23], prev, 13'b0} + 38'(prod);
        m13_r  <= {meas, 13'b0};
        a_sr_r <= {1'b0, alpha};
        w_sr_r <= 17'h10000 - {1'b0, alpha};
        acc_r  <= '0;
        cnt_r  <= 5'd16;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        acc_r  <= acc_nxt;
        a_sr_r <= {a_sr_r[15:0], 1'b0};
        w_sr_r <= {w_sr_r[15:0], 1'b0};
        cnt_r  <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          res_r  <= sat;
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;
endmodule

FILE: src/complementary_attitude_filter_top.sv
// Complementary attitude filter: one sensor sample in, one roll/pitch/yaw
// beat out, angles in 1/128 degree saturated at +/-180 degrees. Samples are
// handled one at a time; in_stall is high from the cycle after acceptance
// until the result has been loaded into the output register. Each sample
// runs two square roots, three atan2 (CORDIC steps capped at 24) and three
// blends one after another, paced by the bit-per-cycle square root, the
// single shared CORDIC stage and the bit-serial blend multiplier. An atan2
// whose two arguments are both zero finishes in the cycle after its start
// instead of iterating, and a result that cannot enter a full, stalled output
// register holds the block for as long as out_stall keeps it full.
// Registers are to be written through the cfg port only while the block is
// idle; the block itself does not enforce this. cfg_ready is always high.
module complementary_attitude_filter_top #(
  parameter int CORDIC_STEPS = caf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [15:0]             in_accel_x,
  input  logic signed [15:0]             in_accel_y,
  input  logic signed [15:0]             in_accel_z,
  input  logic signed [15:0]             in_rate_x,
  input  logic signed [15:0]             in_rate_y,
  input  logic signed [15:0]             in_rate_z,
  input  logic signed [15:0]             in_mag_x,
  input  logic signed [15:0]             in_mag_y,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [15:0]             out_roll_angle,
  output logic signed [15:0]             out_pitch_angle,
  output logic signed [15:0]             out_yaw_angle,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [caf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                    cfg_data
);
  import caf_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQ1  = 4'd1;
  localparam logic [3:0] S_C1   = 4'd2;
  localparam logic [3:0] S_SQ2  = 4'd3;
  localparam logic [3:0] S_C2   = 4'd4;
  localparam logic [3:0] S_C3   = 4'd5;
  localparam logic [3:0] S_B1   = 4'd6;
  localparam logic [3:0] S_B2   = 4'd7;
  localparam logic [3:0] S_B3   = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]         state_r, state_nxt;
  logic [15:0]        alpha_r, ts_r;
  logic signed [15:0] ax_r, ay_r, az_r, rx_r, ry_r, rz_r, mx_r, my_r;
  logic signed [23:0] roll_r, pitch_r, yaw_r;
  logic signed [17:0] mroll_r, mpitch_r, myaw_r;
  logic               out_valid_r;
  logic signed [15:0] oroll_r, opitch_r, oyaw_r;

  logic               sq_start, sq_done;
  logic signed [15:0] sq_p, sq_q;
  logic [15:0]        sq_root;
  logic               cd_start, cd_done;
  logic signed [16:0] cd_y, cd_x, cd_res;
  logic               bl_start, bl_done;
  logic signed [23:0] bl_prev, bl_res;
  logic signed [15:0] bl_rate;
  logic signed [17:0] bl_meas;
  logic               accept, out_load;

  assign accept   = (state_r == S_IDLE) && in_valid;
  assign in_stall = state_r != S_IDLE;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);
  assign cfg_ready = 1'b1;

  caf_sqrt u_sqrt (
    .clk, .rst_n, .start(sq_start), .p(sq_p), .q(sq_q),
    .done(sq_done), .root(sq_root)
  );

  caf_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk, .rst_n, .start(cd_start), .y_in(cd_y), .x_in(cd_x),
    .done(cd_done), .res(cd_res)
  );

  caf_blend u_blend (
    .clk, .rst_n, .start(bl_start), .prev(bl_prev), .rate(bl_rate),
    .meas(bl_meas), .alpha(alpha_r), .tstep(ts_r),
    .done(bl_done), .res(bl_res)
  );

  // operand selection follows the sequencer
  always_comb begin
    state_nxt = state_r;
    sq_start  = 1'b0;
    sq_p      = in_accel_x;
    sq_q      = in_accel_z;
    cd_start  = 1'b0;
    cd_y      = {ay_r[15], ay_r};
    cd_x      = {1'b0, sq_root};
    bl_start  = 1'b0;
    bl_prev   = roll_r;
    bl_rate   = rx_r;
    bl_meas   = mroll_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          sq_start  = 1'b1;
          state_nxt = S_SQ1;
        end
      end
      S_SQ1: begin
        if (sq_done) begin
          cd_start  = 1'b1;
          state_nxt = S_C1;
        end
      end
      S_C1: begin
        sq_p = ay_r;
        sq_q = az_r;
        if (cd_done) begin
          sq_start  = 1'b1;
          state_nxt = S_SQ2;
        end
      end
      S_SQ2: begin
        cd_y = {ax_r[15], ax_r};
        if (sq_done) begin
          cd_start  = 1'b1;
          state_nxt = S_C2;
        end
      end
      S_C2: begin
        cd_y = {mx_r[15], mx_r};
        cd_x = {my_r[15], my_r};
        if (cd_done) begin
          cd_start  = 1'b1;
          state_nxt = S_C3;
        end
      end
      S_C3: begin
        if (cd_done) begin
          bl_start  = 1'b1;
          state_nxt = S_B1;
        end
      end
      S_B1: begin
        bl_prev = pitch_r;
        bl_rate = ry_r;
        bl_meas = mpitch_r;
        if (bl_done) begin
          bl_start  = 1'b1;
          state_nxt = S_B2;
        end
      end
      S_B2: begin
        bl_prev = yaw_r;
        bl_rate = rz_r;
        bl_meas = myaw_r;
        if (bl_done) begin
          bl_start  = 1'b1;
          state_nxt = S_B3;
        end
      end
      S_B3: begin
        if (bl_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      alpha_r     <= ALPHA_RST;
      ts_r        <= TS_RST;
      roll_r      <= '0;
      pitch_r     <= '0;
      yaw_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_ALPHA) alpha_r <= cfg_data;
        else if (cfg_index == REG_TS) ts_r <= cfg_data;
      end
      if ((state_r == S_B1) && bl_done) roll_r  <= bl_res;
      if ((state_r == S_B2) && bl_done) pitch_r <= bl_res;
      if ((state_r == S_B3) && bl_done) yaw_r   <= bl_res;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ax_r <= in_accel_x;
      ay_r <= in_accel_y;
      az_r <= in_accel_z;
      rx_r <= in_rate_x;
      ry_r <= in_rate_y;
      rz_r <= in_rate_z;
      mx_r <= in_mag_x;
      my_r <= in_mag_y;
    end
    if ((state_r == S_C1) && cd_done) mroll_r  <= {cd_res[16], cd_res};
    if ((state_r == S_C2) && cd_done) mpitch_r <= -{cd_res[16], cd_res};
    if ((state_r == S_C3) && cd_done) myaw_r   <= {cd_res[16], cd_res};
    if (out_load) begin
      oroll_r  <= roll_r[15:0];
      opitch_r <= pitch_r[15:0];
      oyaw_r   <= yaw_r[15:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_roll_angle  = oroll_r;
  assign out_pitch_angle = opitch_r;
  assign out_yaw_angle   = oyaw_r;
endmodule

FILE: src/caf_checker.sv
module caf_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [15:0]            out_roll_angle,
  input logic signed [15:0]            out_pitch_angle,
  input logic signed [15:0]            out_yaw_angle,
  input logic                          cfg_ready
);
  // one sample at a time: an accepted beat closes the input side
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while previous sample in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_roll_angle)
      && $stable(out_pitch_angle) && $stable(out_yaw_angle)))
    else $error("stalled result beat changed");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_roll_angle <= 16'sd23040 && out_roll_angle >= -16'sd23040
      && out_pitch_angle <= 16'sd23040 && out_pitch_angle >= -16'sd23040
      && out_yaw_angle <= 16'sd23040 && out_yaw_angle >= -16'sd23040))
    else $error("angle beyond saturation limit");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat after reset");

  a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config port not ready");
endmodule

bind complementary_attitude_filter_top caf_checker u_caf_checker (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
  .out_roll_angle, .out_pitch_angle, .out_yaw_angle, .cfg_ready
);
